>>> rtl/core/jse_pkg.sv
// Package for the string escaper: byte constants, queue sizing and the
// entry type that passes from the front to the back. No dependencies.
`default_nettype none
package jse_pkg;

	localparam logic [7:0] BSLASH     = 8'h5C;
	localparam logic [7:0] LF         = 8'h0A;
	localparam logic [7:0] CR         = 8'h0D;
	localparam logic [7:0] TAB        = 8'h09;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] ESC_N      = 8'h6E;
	localparam logic [7:0] ESC_R      = 8'h72;
	localparam logic [7:0] ESC_T      = 8'h74;

	localparam logic [7:0]  QUOTE_RESET    = 8'd34;
	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic {
		CFG_QUOTE_CHAR = 1'b0,
		CFG_CAPACITY   = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		K_REPORT = 2'd0,
		K_PLAIN  = 2'd1,
		K_ESC    = 2'd2
	} kind_t;

	// data: plain byte, or second byte of an escape; len: length after first byte
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] len;
		logic        trunc;
	} entry_t;

endpackage
`default_nettype wire

>>> rtl/core/jse_ifs.sv
// Valid/ready channel interfaces for the escaper's text input and escaped
// output words. No dependencies.
`default_nettype none
interface jse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_marker;

	modport source (output valid, output in_byte, output end_marker, input ready);
	modport sink (input valid, input in_byte, input end_marker, output ready);
endinterface

interface jse_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        is_report;
	logic        run_last;
	logic [15:0] total_length;
	logic        truncated;

	modport source (output valid, output out_byte, output is_report, output run_last,
		output total_length, output truncated, input ready);
	modport sink (input valid, input out_byte, input is_report, input run_last,
		input total_length, input truncated, output ready);
endinterface
`default_nettype wire

>>> rtl/core/jse_front.sv
// Front end: takes text words, classifies each byte, applies the capacity
// rule and keeps the running length. Uses jse_pkg and jse_in_if.
`default_nettype none
module jse_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	jse_in_if.sink               text,
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire logic [15:0]     cfg_data,
	input  wire logic            q_full,
	output logic                 q_push,
	output jse_pkg::entry_t      q_entry
);
	import jse_pkg::*;

	logic [7:0]  quote_q;
	logic [15:0] cap_q;
	logic [15:0] wc_q;
	logic        stopped_q;

	logic        esc, drop, fit, accept;
	logic [7:0]  b, sec;
	logic [16:0] need;

	always_comb begin
		b    = text.in_byte;
		esc  = 1'b1;
		drop = 1'b0;
		sec  = b;
		priority if (b == BSLASH || b == quote_q) begin
			sec = b;
		end else if (b == LF) begin
			sec = ESC_N;
		end else if (b == CR) begin
			sec = ESC_R;
		end else if (b == TAB) begin
			sec = ESC_T;
		end else begin
			esc  = 1'b0;
			drop = (b < CTRL_LIMIT);
		end
		need = {1'b0, wc_q} + (esc ? 17'd3 : 17'd2);
		fit  = (need <= {1'b0, cap_q});
	end

	assign text.ready = !q_full;
	assign accept     = text.valid && text.ready;
	assign q_push     = accept && (text.end_marker || (!stopped_q && !drop && fit));

	always_comb begin
		q_entry.trunc = 1'b0;
		q_entry.len   = wc_q + 16'd1;
		q_entry.data  = esc ? sec : b;
		q_entry.kind  = esc ? K_ESC : K_PLAIN;
		if (text.end_marker) begin
			q_entry.kind  = K_REPORT;
			q_entry.data  = 8'd0;
			q_entry.len   = wc_q;
			q_entry.trunc = stopped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= QUOTE_RESET;
			cap_q   <= CAPACITY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_QUOTE_CHAR: quote_q <= cfg_data[7:0];
				CFG_CAPACITY:   cap_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q      <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (text.end_marker) begin
				wc_q      <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q && !drop) begin
				if (!fit) begin
					stopped_q <= 1'b1;
				end else begin
					wc_q <= wc_q + (esc ? 16'd2 : 16'd1);
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/jse_queue.sv
// Short FIFO of classified entries between front and back.
// Uses jse_pkg for the entry type and depth.
`default_nettype none
module jse_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire jse_pkg::entry_t push_entry,
	output logic                 full,
	input  wire logic            pop,
	output jse_pkg::entry_t      head,
	output logic                 nempty
);
	import jse_pkg::*;

	entry_t        mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;

	assign full   = (cnt_q == (QAW+1)'(QDEPTH));
	assign nempty = (cnt_q != '0);
	assign head   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QAW'(1);
			if (pop)  rd_q <= rd_q + QAW'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/jse_back.sv
// Back end: expands queue entries into output words, one byte per word,
// through a registered output. Uses jse_pkg and jse_out_if.
`default_nettype none
module jse_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire jse_pkg::entry_t head,
	input  wire logic            nempty,
	output logic                 pop,
	jse_out_if.source            escaped
);
	import jse_pkg::*;

	logic        ov_q;
	logic [7:0]  ob_q;
	logic        orep_q, olast_q, otr_q;
	logic [15:0] olen_q;

	// second byte of an escape waiting for the output register
	logic        pend_q;
	logic [7:0]  pb_q;
	logic [15:0] plen_q;

	logic can_load;

	assign can_load = !ov_q || escaped.ready;
	assign pop      = can_load && !pend_q && nempty;

	assign escaped.valid        = ov_q;
	assign escaped.out_byte     = ob_q;
	assign escaped.is_report    = orep_q;
	assign escaped.run_last     = olast_q;
	assign escaped.total_length = olen_q;
	assign escaped.truncated    = otr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			pend_q <= 1'b0;
		end else if (can_load) begin
			if (pend_q) begin
				ov_q   <= 1'b1;
				pend_q <= 1'b0;
			end else begin
				ov_q   <= nempty;
				pend_q <= nempty && (head.kind == K_ESC);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			if (pend_q) begin
				ob_q    <= pb_q;
				orep_q  <= 1'b0;
				olast_q <= 1'b1;
				olen_q  <= plen_q;
				otr_q   <= 1'b0;
			end else if (nempty) begin
				olen_q <= head.len;
				otr_q  <= head.trunc;
				pb_q   <= head.data;
				plen_q <= head.len + 16'd1;
				unique case (head.kind)
					K_ESC: begin
						ob_q    <= BSLASH;
						orep_q  <= 1'b0;
						olast_q <= 1'b0;
					end
					K_PLAIN: begin
						ob_q    <= head.data;
						orep_q  <= 1'b0;
						olast_q <= 1'b1;
					end
					default: begin
						ob_q    <= head.data;
						orep_q  <= 1'b1;
						olast_q <= 1'b1;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/js_string_escape_top.sv
// Top level of the script string escaper: front end, entry queue, back end.
// Uses jse_pkg, jse_ifs, jse_front, jse_queue and jse_back.
//
// Text words enter on text, escaped words leave on escaped, one byte each.
// A plain byte or an end report gives one word, a two-byte escape gives two
// words through the single-byte output register; the back end pops no
// new entry until the second byte is loaded. Dropped bytes and bytes after
// truncation are accepted but give no word. A four-entry queue parts input
// from output, so input keeps flowing while output stalls until the queue
// fills. Write quote_char (index 0) and capacity (index 1) only while idle.
`default_nettype none
module js_string_escape_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	jse_in_if.sink           text,
	jse_out_if.source        escaped,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);
	import jse_pkg::*;

	entry_t q_entry, head;
	logic   q_push, q_full, pop, nempty;

	jse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	jse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_entry),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.nempty    (nempty)
	);

	jse_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.nempty (nempty),
		.pop    (pop),
		.escaped(escaped)
	);

endmodule
`default_nettype wire

>>> test/js_string_escape_top_tb.sv
// Testbench for js_string_escape_top: directed and random text streams, checked
// word by word against an in-bench escaper model. Uses jse_pkg and jse_ifs.
module js_string_escape_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import jse_pkg::*;

	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 80;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_report;
		logic        run_last;
		logic [15:0] total_length;
		logic        truncated;
	} esc_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	cfg_idx_t    cfg_index;
	logic [15:0] cfg_data;

	jse_in_if  text_ch();
	jse_out_if esc_ch();

	js_string_escape_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text_ch),
		.escaped  (esc_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	esc_word_t   pending_words[$];
	int          err_count;
	int          items_sent;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_left;

	logic [7:0]  mdl_quote;
	logic [15:0] mdl_cap;
	logic [15:0] mdl_written;
	bit          mdl_stopped;

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
		end
	endtask

	task automatic push_word(input logic [7:0] b, input logic rep, input logic last,
		input logic [15:0] len, input logic trunc);
		esc_word_t w;
		w = '{out_byte: b, is_report: rep, run_last: last, total_length: len, truncated: trunc};
		pending_words.push_back(w);
	endtask

	task automatic predict_escape(input logic [7:0] b, input logic end_mark);
		logic [7:0] second;
		bit         esc;
		if (end_mark) begin
			push_word(8'h00, 1'b1, 1'b1, mdl_written, mdl_stopped);
			mdl_written = '0;
			mdl_stopped = 1'b0;
			return;
		end
		if (mdl_stopped) return;
		esc = 1'b1;
		second = b;
		if (b == BSLASH || b == mdl_quote) begin
			second = b;
		end else if (b == LF) begin
			second = ESC_N;
		end else if (b == CR) begin
			second = ESC_R;
		end else if (b == TAB) begin
			second = ESC_T;
		end else begin
			esc = 1'b0;
			if (b < CTRL_LIMIT) return;
		end
		if (esc) begin
			if (int'(mdl_written) + 3 > int'(mdl_cap)) begin
				mdl_stopped = 1'b1;
				return;
			end
			mdl_written++;
			push_word(BSLASH, 1'b0, 1'b0, mdl_written, 1'b0);
			mdl_written++;
			push_word(second, 1'b0, 1'b1, mdl_written, 1'b0);
		end else begin
			if (int'(mdl_written) + 2 > int'(mdl_cap)) begin
				mdl_stopped = 1'b1;
				return;
			end
			mdl_written++;
			push_word(b, 1'b0, 1'b1, mdl_written, 1'b0);
		end
	endtask

	always @(posedge clk) begin : check_words
		esc_word_t want;
		if (arst_n && esc_ch.valid && esc_ch.ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %02h", esc_ch.out_byte));
			end else begin
				want = pending_words.pop_front();
				check_field("out_byte", esc_ch.out_byte, want.out_byte);
				check_field("is_report", esc_ch.is_report, want.is_report);
				check_field("run_last", esc_ch.run_last, want.run_last);
				check_field("total_length", esc_ch.total_length, want.total_length);
				check_field("truncated", esc_ch.truncated, want.truncated);
			end
		end
	end

	initial begin
		esc_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				esc_ch.ready = 1'b0;
				hold_left--;
			end else begin
				esc_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic end_mark);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			text_ch.valid = 1'b0;
			@(negedge clk);
		end
		text_ch.valid      = 1'b1;
		text_ch.in_byte    = b;
		text_ch.end_marker = end_mark;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		predict_escape(b, end_mark);
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		text_ch.valid = 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_QUOTE_CHAR) mdl_quote = val[7:0];
		else mdl_cap = val;
	endtask

	task automatic send_list(input logic [8:0] words[]);
		foreach (words[i]) send_word(words[i][7:0], words[i][8]);
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 8'($urandom_range(8'h20, 8'h7E));
		if (r < 55) return 8'($urandom_range(8'h80, 8'hFF));
		if (r < 65) return 8'($urandom_range(8'h00, 8'h1F));
		if (r < 75) begin
			case ($urandom_range(0, 2))
				0: return TAB;
				1: return LF;
				default: return CR;
			endcase
		end
		if (r < 84) return BSLASH;
		if (r < 93) return mdl_quote;
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] pick_capacity();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 16'($urandom_range(0, 1));
		if (r < 65) return 16'($urandom_range(2, 40));
		if (r < 88) return 16'($urandom_range(41, 300));
		if (r < 94) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_quote();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 16'd34;
		if (r < 70) return 16'd39;
		return 16'($urandom_range(0, 255));
	endfunction

	task automatic test_default_escapes();
		send_list('{9'h041, 9'h000, 9'h01F, 9'h009, 9'h00A, 9'h00D, 9'h05C, 9'h022,
			9'h027, 9'h020, 9'h0FF, 9'h1FF});
	endtask

	task automatic test_quote_select();
		wait_drained();
		cfg_write(CFG_QUOTE_CHAR, 16'h0000);
		send_list('{9'h000, 9'h022});
		wait_drained();
		cfg_write(CFG_QUOTE_CHAR, 16'h00FF);
		send_list('{9'h0FF, 9'h100});
		wait_drained();
		cfg_write(CFG_QUOTE_CHAR, 16'h000A);
		send_list('{9'h00A, 9'h100});
	endtask

	task automatic test_capacity_limits();
		wait_drained();
		cfg_write(CFG_QUOTE_CHAR, 16'd34);
		cfg_write(CFG_CAPACITY, 16'h0000);
		send_list('{9'h041, 9'h100});
		wait_drained();
		cfg_write(CFG_CAPACITY, 16'h0001);
		send_list('{9'h001, 9'h05C, 9'h100});
		wait_drained();
		cfg_write(CFG_CAPACITY, 16'h0003);
		send_list('{9'h041, 9'h001, 9'h00A, 9'h042, 9'h100});
		wait_drained();
		cfg_write(CFG_CAPACITY, 16'hFFFF);
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		wait_drained();
		// output held off while the sender keeps pushing escapes
		hold_left = HOLD_CYCLES;
		repeat (16) send_word(($urandom_range(0, 1) != 0) ? BSLASH : LF, 1'b0);
		send_word(8'h41, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_text(input int n_items, input int send_pct, input int stall_pct);
		int target;
		int len;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		target = items_sent + n_items;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) == 0) begin
				wait_drained();
				if ($urandom_range(0, 1) != 0) cfg_write(CFG_QUOTE_CHAR, pick_quote());
				cfg_write(CFG_CAPACITY, pick_capacity());
			end
			len = $urandom_range(0, 24);
			if ($urandom_range(0, 99) < 85) begin
				repeat (len) send_word(pick_byte(), 1'b0);
				send_word(8'($urandom), 1'b1);
			end else begin
				repeat (len / 4 + 1) send_word(8'($urandom), $urandom_range(0, 3) == 0);
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_QUOTE_CHAR;
		cfg_data           = '0;
		text_ch.valid      = 1'b0;
		text_ch.in_byte    = '0;
		text_ch.end_marker = 1'b0;
		mdl_quote          = QUOTE_RESET;
		mdl_cap            = CAPACITY_RESET;
		mdl_written        = '0;
		mdl_stopped        = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_escapes();
		test_quote_select();
		test_capacity_limits();
		test_backpressure();
		test_random_text(255, 0, 0);
		test_random_text(255, 78, 0);
		test_random_text(255, 0, 78);
		test_random_text(255, 13, 13);

		wait_drained();
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
